// File: rtl/core/pcs_pkg.sv
// Shared widths, constants and the contour record for the shoelace centroid core.
// Used by pcs_front, pcs_queue, pcs_back and polygon_centroid_shoelace_core.
`default_nettype none

package pcs_pkg;

    localparam int COORD_BITS  = 12;
    localparam int AREA_BITS   = 40;
    localparam int MOMENT_BITS = 52;

    // edge datapath
    localparam int PROD_BITS  = 2 * COORD_BITS;          // x0*y1
    localparam int CROSS_BITS = PROD_BITS + 1;           // signed cross product
    localparam int SUM_BITS   = COORD_BITS + 1;          // x0+x1
    localparam int TERM_BITS  = SUM_BITS + 1 + CROSS_BITS; // signed moment term

    // divider
    localparam int DEN_BITS  = AREA_BITS + 1;            // |3*area|
    localparam int DIVD_BITS = MOMENT_BITS + 1;          // 2|num| + |den|
    localparam int DSH_BITS  = DEN_BITS + 1 + COORD_BITS; // 2|den| << COORD_BITS
    localparam int STEP_BITS = $clog2(COORD_BITS + 1);

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [AREA_BITS-1:0]   area;
        logic [MOMENT_BITS-1:0] mom_x;
        logic [MOMENT_BITS-1:0] mom_y;
        logic                   ok;
    } t_contour;

endpackage

`default_nettype wire

// File: rtl/core/polygon_centroid_shoelace_core.sv
// Top level of the shoelace polygon centroid core: front end, contour queue,
// back-end divider. Depends on pcs_pkg, pcs_front, pcs_queue and pcs_back.
//
//   channel  | direction | handshake                 | payload
//   vertex   | in        | i_in_valid / o_in_stall   | i_px, i_py, i_last_point
//   centroid | out       | o_out_valid / i_out_stall | o_cx, o_cy, o_centroid_ok
//
// A vertex that does not close its contour is taken every cycle while the queue
// has room; the edge pipeline has product, cross-product and moment-term stages.
// After a last vertex the input stalls while the closing edge runs through the
// pipeline into the queue. Per contour the back end does setup and two restoring
// divisions of up to 13 steps; QUEUE_DEPTH contours wait ahead of it, and the
// input stalls when the queue is full. Reset is synchronous; no clearing pass.
`default_nettype none

module polygon_centroid_shoelace_core #(
    parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [pcs_pkg::COORD_BITS-1:0] i_px,
    input  wire logic [pcs_pkg::COORD_BITS-1:0] i_py,
    input  wire logic                           i_last_point,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [pcs_pkg::COORD_BITS-1:0]      o_cx,
    output logic [pcs_pkg::COORD_BITS-1:0]      o_cy,
    output logic                                o_centroid_ok
);

    logic              q_full, q_empty, q_push, q_pop;
    pcs_pkg::t_contour q_push_data, q_head;

    pcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_px         (i_px),
        .i_py         (i_py),
        .i_last_point (i_last_point),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_push_data  (q_push_data)
    );

    pcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    pcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cx          (o_cx),
        .o_cy          (o_cy),
        .o_centroid_ok (o_centroid_ok)
    );

endmodule

`default_nettype wire

// File: rtl/core/pcs_front.sv
// Front end: takes vertices, forms edges, runs the cross/moment pipeline and
// accumulates per-contour sums. Depends on pcs_pkg.
`default_nettype none

module pcs_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [pcs_pkg::COORD_BITS-1:0] i_px,
    input  wire logic [pcs_pkg::COORD_BITS-1:0] i_py,
    input  wire logic                           i_last_point,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output pcs_pkg::t_contour                   o_push_data
);

    localparam int CB = pcs_pkg::COORD_BITS;
    localparam int PB = pcs_pkg::PROD_BITS;
    localparam int XB = pcs_pkg::CROSS_BITS;
    localparam int SB = pcs_pkg::SUM_BITS;
    localparam int TB = pcs_pkg::TERM_BITS;
    localparam int AB = pcs_pkg::AREA_BITS;
    localparam int MB = pcs_pkg::MOMENT_BITS;

    typedef enum logic [1:0] {F_RUN, F_CLOSE, F_WAIT} t_fstate;

    t_fstate r_state;
    logic [CB-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [1:0]    r_count;

    // stage 1: products and coordinate sums
    logic          r_v1, r_close1, r_ok1;
    logic [PB-1:0] r_p1, r_p2;
    logic [SB-1:0] r_sx1, r_sy1;
    // stage 2: cross product
    logic                 r_v2, r_close2, r_ok2;
    logic signed [XB-1:0] r_c2;
    logic [SB-1:0]        r_sx2, r_sy2;
    // stage 3: moment terms
    logic                 r_v3, r_close3, r_ok3;
    logic signed [XB-1:0] r_c3;
    logic signed [TB-1:0] r_mx3, r_my3;
    // accumulators
    logic [AB-1:0] r_area;
    logic [MB-1:0] r_mom_x, r_mom_y;

    logic          accept;
    logic          edge_go;
    logic [CB-1:0] x1, y1;
    logic [AB-1:0] area_new;
    logic [MB-1:0] mom_x_new, mom_y_new;

    assign o_in_stall = (r_state != F_RUN) || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign edge_go    = (accept && (r_count != 2'd0)) || (r_state == F_CLOSE);
    assign x1         = (r_state == F_CLOSE) ? r_first_x : i_px;
    assign y1         = (r_state == F_CLOSE) ? r_first_y : i_py;

    assign area_new  = r_area + {{(AB-XB){r_c3[XB-1]}}, r_c3};
    assign mom_x_new = r_mom_x + {{(MB-TB){r_mx3[TB-1]}}, r_mx3};
    assign mom_y_new = r_mom_y + {{(MB-TB){r_my3[TB-1]}}, r_my3};

    assign o_push             = r_v3 && r_close3;
    assign o_push_data.area   = area_new;
    assign o_push_data.mom_x  = mom_x_new;
    assign o_push_data.mom_y  = mom_y_new;
    assign o_push_data.ok     = r_ok3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_RUN;
            r_count   <= 2'd0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_area    <= '0;
            r_mom_x   <= '0;
            r_mom_y   <= '0;
        end else begin
            unique case (r_state)
                F_RUN: begin
                    if (accept) begin
                        if (r_count == 2'd0) begin
                            r_first_x <= i_px;
                            r_first_y <= i_py;
                            r_count   <= 2'd1;
                        end else if (r_count != 2'd3) begin
                            r_count <= r_count + 2'd1;
                        end
                        r_prev_x <= i_px;
                        r_prev_y <= i_py;
                        if (i_last_point) begin
                            r_state <= F_CLOSE;
                        end
                    end
                end
                F_CLOSE: begin
                    // closing edge enters now; contour state starts over
                    r_count <= 2'd0;
                    r_state <= F_WAIT;
                end
                F_WAIT: begin
                    if (o_push) begin
                        r_state <= F_RUN;
                    end
                end
                default: r_state <= F_RUN;
            endcase

            r_v1 <= edge_go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;

            if (r_v3) begin
                if (r_close3) begin
                    r_area  <= '0;
                    r_mom_x <= '0;
                    r_mom_y <= '0;
                end else begin
                    r_area  <= area_new;
                    r_mom_x <= mom_x_new;
                    r_mom_y <= mom_y_new;
                end
            end
        end
    end

    // edge pipeline payload
    always_ff @(posedge i_clk) begin
        if (edge_go) begin
            r_p1     <= PB'(r_prev_x) * PB'(y1);
            r_p2     <= PB'(x1) * PB'(r_prev_y);
            r_sx1    <= {1'b0, r_prev_x} + {1'b0, x1};
            r_sy1    <= {1'b0, r_prev_y} + {1'b0, y1};
            r_close1 <= (r_state == F_CLOSE);
            r_ok1    <= (r_count == 2'd3);
        end
        r_c2     <= $signed({1'b0, r_p1}) - $signed({1'b0, r_p2});
        r_sx2    <= r_sx1;
        r_sy2    <= r_sy1;
        r_close2 <= r_close1;
        r_ok2    <= r_ok1;

        r_mx3    <= TB'($signed({1'b0, r_sx2})) * TB'(r_c2);
        r_my3    <= TB'($signed({1'b0, r_sy2})) * TB'(r_c2);
        r_c3     <= r_c2;
        r_close3 <= r_close2;
        r_ok3    <= r_ok2;
    end

endmodule

`default_nettype wire

// File: rtl/core/pcs_queue.sv
// Short FIFO of finished contour sums between front and back ends.
// Depends on pcs_pkg for the record type.
`default_nettype none

module pcs_queue #(
    parameter int DEPTH = pcs_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire pcs_pkg::t_contour i_push_data,
    input  wire logic        i_pop,
    output pcs_pkg::t_contour o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    pcs_pkg::t_contour r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_BITS-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_BITS'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pcs_back.sv
// Back end: divides each moment by three times the area with a radix-2
// restoring divider, rounds, clamps and holds the result. Depends on pcs_pkg.
`default_nettype none

module pcs_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_empty,
    input  wire pcs_pkg::t_contour         i_head,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [pcs_pkg::COORD_BITS-1:0] o_cx,
    output logic [pcs_pkg::COORD_BITS-1:0] o_cy,
    output logic                           o_centroid_ok
);

    localparam int CB  = pcs_pkg::COORD_BITS;
    localparam int AB  = pcs_pkg::AREA_BITS;
    localparam int MB  = pcs_pkg::MOMENT_BITS;
    localparam int DB  = pcs_pkg::DEN_BITS;
    localparam int VB  = pcs_pkg::DIVD_BITS;
    localparam int HB  = pcs_pkg::DSH_BITS;
    localparam int STB = pcs_pkg::STEP_BITS;

    typedef enum logic [2:0] {B_IDLE, B_DEN, B_ABS, B_LOAD, B_DIV, B_OUT} t_bstate;

    t_bstate r_state;
    logic [AB-1:0]  r_area;
    logic [MB-1:0]  r_mom_x, r_mom_y;
    logic           r_ok, r_okf;
    logic [DB-1:0]  r_den_abs;
    logic           r_den_neg;
    logic           r_sel;
    logic [MB-1:0]  r_num_abs;
    logic           r_neg;
    logic [VB-1:0]  r_rem;
    logic [HB-1:0]  r_dsh;
    logic [STB-1:0] r_step;
    logic [CB-1:0]  r_q;
    logic [CB-1:0]  r_cx, r_cy;
    logic           r_o_valid;
    logic [CB-1:0]  r_o_cx, r_o_cy;
    logic           r_o_ok;

    logic signed [AB+1:0] den3;
    logic [AB+1:0]        den3_neg;
    logic [MB-1:0]        num;
    logic                 ge;
    logic                 top_step;
    logic [CB-1:0]        q_next;
    logic [CB-1:0]        coord;
    logic                 out_load;

    assign o_pop         = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid   = r_o_valid;
    assign o_cx          = r_o_cx;
    assign o_cy          = r_o_cy;
    assign o_centroid_ok = r_o_ok;

    assign den3     = $signed({{2{r_area[AB-1]}}, r_area}) + $signed({r_area[AB-1], r_area, 1'b0});
    assign den3_neg = -den3;
    assign num      = r_sel ? r_mom_y : r_mom_x;
    assign ge       = ({1'b0, r_rem} >= r_dsh);
    assign top_step = (r_step == STB'(CB));
    assign q_next   = {r_q[CB-2:0], ge};
    assign out_load = (r_state == B_OUT) && (!r_o_valid || !i_out_stall);

    // negative quotients clamp to zero, oversized ones to full scale
    always_comb begin
        priority if (r_neg) begin
            coord = '0;
        end else if (top_step) begin
            coord = {CB{1'b1}};
        end else begin
            coord = q_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // load a new result, or drop the one just taken
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_area  <= i_head.area;
                        r_mom_x <= i_head.mom_x;
                        r_mom_y <= i_head.mom_y;
                        r_ok    <= i_head.ok;
                        r_state <= B_DEN;
                    end
                end
                B_DEN: begin
                    r_den_neg <= den3[AB+1];
                    r_den_abs <= den3[AB+1] ? den3_neg[DB-1:0] : den3[DB-1:0];
                    r_okf     <= r_ok && (r_area != '0);
                    r_sel     <= 1'b0;
                    r_state   <= B_ABS;
                end
                B_ABS: begin
                    r_num_abs <= num[MB-1] ? -num : num;
                    r_neg     <= num[MB-1] ^ r_den_neg;
                    r_state   <= B_LOAD;
                end
                B_LOAD: begin
                    r_rem   <= {r_num_abs, 1'b0} + {{(VB-DB){1'b0}}, r_den_abs};
                    r_dsh   <= {r_den_abs, 1'b0, {CB{1'b0}}};
                    r_step  <= STB'(CB);
                    r_q     <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    if (!top_step) begin
                        r_q <= q_next;
                        if (ge) begin
                            r_rem <= r_rem - r_dsh[VB-1:0];
                        end
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_step <= r_step - 1'b1;
                    if ((top_step && ge) || (r_step == '0)) begin
                        if (!r_sel) begin
                            r_cx    <= coord;
                            r_sel   <= 1'b1;
                            r_state <= B_ABS;
                        end else begin
                            r_cy    <= coord;
                            r_state <= B_OUT;
                        end
                    end
                end
                B_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_o_cx    <= r_okf ? r_cx : '0;
                        r_o_cy    <= r_okf ? r_cy : '0;
                        r_o_ok    <= r_okf;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
